### src/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the ChaCha20 stream cipher
// Payload structs, configuration register map, round step codes and the
// fixed state words.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [31:0] SIGMA_0     = 32'h61707865;
    localparam logic [31:0] SIGMA_1     = 32'h3320646e;
    localparam logic [31:0] SIGMA_2     = 32'h79622d32;
    localparam logic [31:0] SIGMA_3     = 32'h6b206574;
    localparam logic [31:0] COUNTER_MAX = 32'hffffffff;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int STATE_WORDS   = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KEY_0     = 3'd0,
        REG_KEY_1     = 3'd1,
        REG_KEY_2     = 3'd2,
        REG_KEY_3     = 3'd3,
        REG_NONCE_0   = 3'd4,
        REG_NONCE_1   = 3'd5,
        REG_START_CTR = 3'd6
    } cfg_reg_t;

    // Four steps of one quarter round: add into a or c, then xor-rotate
    typedef enum logic [1:0] {
        STEP_A16 = 2'd0,
        STEP_C12 = 2'd1,
        STEP_A8  = 2'd2,
        STEP_C7  = 2'd3
    } qr_step_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_of_message;
    } in_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       status;
    } out_t;

endpackage

### src/ccs_qr_unit.sv
// ----------------------------------------------------------------------------
// ccs_qr_unit: shared add / xor / rotate unit
// Computes one step of a quarter round: sum = p + q, mix = rotl(r ^ sum, n)
// with the rotate amount set by the step code.
// ----------------------------------------------------------------------------
module ccs_qr_unit (
    input  logic [31:0]       p,
    input  logic [31:0]       q,
    input  logic [31:0]       r,
    input  ccs_pkg::qr_step_t step,
    output logic [31:0]       sum,
    output logic [31:0]       mix
);
    import ccs_pkg::*;

    logic [31:0] x;

    assign sum = p + q;
    assign x   = r ^ sum;

    always_comb
    begin
        unique case (step)
            STEP_A16: mix = {x[15:0], x[31:16]};
            STEP_C12: mix = {x[19:0], x[31:20]};
            STEP_A8:  mix = {x[23:0], x[31:24]};
            STEP_C7:  mix = {x[24:0], x[31:25]};
        endcase
    end

endmodule

### src/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher: byte-serial ChaCha20 encrypt / decrypt
// Each input byte is XORed with the next keystream byte (0 once exhausted).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one byte and a last flag per
//   transfer; output channel out_valid / out_stall returns one result byte
//   and a status bit per input byte, in order.
//   Configuration (key, nonce, start counter) is written through cfg_wr_en,
//   cfg_addr, cfg_wdata while no byte is in flight.
//   A 64-byte keystream block is generated on the first byte that needs it,
//   by one add/xor/rotate unit stepping through the quarter rounds: a load,
//   ten double rounds (32 steps, 2 row shifts each), a 16-word feed-forward.
//   Within a block a byte is taken every cycle while the output does not
//   stall; the byte is held in an input register, its result in the output one.
//   A held input byte plus the output register let one byte be accepted
//   while a result waits; a stalled output then stalls the input.
//   Reset clears the configuration, sequencer, message state and handshake
//   flags; the first byte after reset starts a new message.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ccs_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ccs_pkg::out_t                  out_data,
    input  logic                           cfg_wr_en,
    input  logic [ccs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ccs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_ROUND  = 6'b000100,
        ST_DIAG   = 6'b001000,
        ST_UNDIAG = 6'b010000,
        ST_FEED   = 6'b100000
    } state_t;

    // configuration
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce0_reg;
    logic [31:0] nonce1_reg, start_ctr_reg;

    // message state
    logic [31:0] counter_reg;
    logic [5:0]  off_reg;
    logic        ks_ready_reg, exh_reg, msg_active_reg;

    // sequencer
    state_t      state_reg;
    qr_step_t    step_reg;
    logic [1:0]  qr_reg;
    logic        pass_reg;
    logic [3:0]  dround_reg;
    logic [3:0]  ff_reg;

    // working state, holds the keystream block after feed-forward
    logic [31:0] w_reg  [STATE_WORDS];
    logic [31:0] w_next [STATE_WORDS];
    logic [31:0] w_step [STATE_WORDS];
    logic [31:0] init_w [STATE_WORDS];

    // handshake
    in_t         item_reg;
    logic        pending_reg;
    logic        out_valid_reg;
    out_t        out_data_reg;

    logic [31:0] eff_counter;
    logic [5:0]  eff_off;
    logic        eff_ready, eff_exh;
    logic        idle, slot_free, need_gen, produce, in_fire, out_fire;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;
    logic [5:0]  off_inc;

    logic [31:0] u_p, u_q, u_r, u_sum, u_mix;

    // ---------------------------------------------------------------- control
    assign eff_counter = msg_active_reg ? counter_reg : start_ctr_reg;
    assign eff_off     = msg_active_reg ? off_reg : 6'd0;
    assign eff_ready   = msg_active_reg & ks_ready_reg;
    assign eff_exh     = msg_active_reg & exh_reg;

    assign idle      = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign need_gen  = pending_reg && idle && !eff_exh && !eff_ready;
    assign produce   = pending_reg && idle && (eff_exh || eff_ready) && slot_free;
    assign in_stall  = pending_reg && !produce;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign ks_word = w_reg[eff_off[5:2]];
    assign ks_byte = 8'(ks_word >> {eff_off[1:0], 3'b000});
    assign off_inc = eff_off + 6'd1;

    // ------------------------------------------------------- initial state
    always_comb
    begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = SIGMA_1;
        init_w[2]  = SIGMA_2;
        init_w[3]  = SIGMA_3;
        init_w[4]  = key0_reg[31:0];
        init_w[5]  = key0_reg[63:32];
        init_w[6]  = key1_reg[31:0];
        init_w[7]  = key1_reg[63:32];
        init_w[8]  = key2_reg[31:0];
        init_w[9]  = key2_reg[63:32];
        init_w[10] = key3_reg[31:0];
        init_w[11] = key3_reg[63:32];
        init_w[12] = counter_reg;
        init_w[13] = nonce0_reg[31:0];
        init_w[14] = nonce0_reg[63:32];
        init_w[15] = nonce1_reg;
    end

    // -------------------------------------------------------- shared unit
    always_comb
    begin
        if (state_reg == ST_FEED)
        begin
            u_p = w_reg[0];
            u_q = init_w[ff_reg];
            u_r = w_reg[12];
        end
        else
        begin
            unique case (step_reg)
                STEP_A16, STEP_A8:
                begin
                    u_p = w_reg[0];
                    u_q = w_reg[4];
                    u_r = w_reg[12];
                end
                STEP_C12, STEP_C7:
                begin
                    u_p = w_reg[8];
                    u_q = w_reg[12];
                    u_r = w_reg[4];
                end
            endcase
        end
    end

    ccs_qr_unit u_qr (
        .p    (u_p),
        .q    (u_q),
        .r    (u_r),
        .step (step_reg),
        .sum  (u_sum),
        .mix  (u_mix)
    );

    // The quarter round always works on column 0; rows rotate to bring the
    // next column or diagonal into place.
    always_comb
    begin
        w_step = w_reg;
        unique case (step_reg)
            STEP_A16, STEP_A8:
            begin
                w_step[0]  = u_sum;
                w_step[12] = u_mix;
            end
            STEP_C12, STEP_C7:
            begin
                w_step[8] = u_sum;
                w_step[4] = u_mix;
            end
        endcase
    end

    always_comb
    begin
        w_next = w_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                w_next = w_reg;
            end
            ST_LOAD:
            begin
                w_next = init_w;
            end
            ST_ROUND:
            begin
                if (step_reg == STEP_C7)
                begin
                    // quarter round done: advance every row by one column
                    for (int rr = 0; rr < 4; rr++)
                    begin
                        for (int cc = 0; cc < 4; cc++)
                        begin
                            w_next[4*rr+cc] = w_step[4*rr + ((cc+1) & 3)];
                        end
                    end
                end
                else
                begin
                    w_next = w_step;
                end
            end
            ST_DIAG:
            begin
                for (int rr = 0; rr < 4; rr++)
                begin
                    for (int cc = 0; cc < 4; cc++)
                    begin
                        w_next[4*rr+cc] = w_reg[4*rr + ((cc+rr) & 3)];
                    end
                end
            end
            ST_UNDIAG:
            begin
                for (int rr = 0; rr < 4; rr++)
                begin
                    for (int cc = 0; cc < 4; cc++)
                    begin
                        w_next[4*rr+cc] = w_reg[4*rr + ((cc+4-rr) & 3)];
                    end
                end
            end
            ST_FEED:
            begin
                // shift the ring, add the initial word at the tail
                for (int i = 0; i < STATE_WORDS-1; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[STATE_WORDS-1] = u_sum;
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    // ------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            nonce0_reg    <= '0;
            nonce1_reg    <= '0;
            start_ctr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_KEY_0:     key0_reg      <= cfg_wdata;
                REG_KEY_1:     key1_reg      <= cfg_wdata;
                REG_KEY_2:     key2_reg      <= cfg_wdata;
                REG_KEY_3:     key3_reg      <= cfg_wdata;
                REG_NONCE_0:   nonce0_reg    <= cfg_wdata;
                REG_NONCE_1:   nonce1_reg    <= cfg_wdata[31:0];
                REG_START_CTR: start_ctr_reg <= cfg_wdata[31:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= STEP_A16;
            qr_reg     <= '0;
            pass_reg   <= 1'b0;
            dround_reg <= '0;
            ff_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (need_gen)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    step_reg   <= STEP_A16;
                    qr_reg     <= '0;
                    pass_reg   <= 1'b0;
                    dround_reg <= '0;
                    state_reg  <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    step_reg <= qr_step_t'(step_reg + 2'd1);
                    if (step_reg == STEP_C7)
                    begin
                        qr_reg <= qr_reg + 2'd1;
                        if (qr_reg == 2'd3)
                        begin
                            state_reg <= pass_reg ? ST_UNDIAG : ST_DIAG;
                        end
                    end
                end
                ST_DIAG:
                begin
                    pass_reg  <= 1'b1;
                    state_reg <= ST_ROUND;
                end
                ST_UNDIAG:
                begin
                    pass_reg <= 1'b0;
                    if (dround_reg == 4'(DOUBLE_ROUNDS - 1))
                    begin
                        ff_reg    <= '0;
                        state_reg <= ST_FEED;
                    end
                    else
                    begin
                        dround_reg <= dround_reg + 4'd1;
                        state_reg  <= ST_ROUND;
                    end
                end
                ST_FEED:
                begin
                    ff_reg <= ff_reg + 4'd1;
                    if (ff_reg == 4'(STATE_WORDS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // -------------------------------------------------------- message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            off_reg        <= '0;
            ks_ready_reg   <= 1'b0;
            exh_reg        <= 1'b0;
            msg_active_reg <= 1'b0;
        end
        else
        begin
            if (need_gen)
            begin
                // start of message or new block: latch the block counter
                counter_reg    <= eff_counter;
                off_reg        <= eff_off;
                ks_ready_reg   <= 1'b0;
                exh_reg        <= 1'b0;
                msg_active_reg <= 1'b1;
            end
            else if (produce)
            begin
                msg_active_reg <= !item_reg.last_of_message;
                if (!eff_exh)
                begin
                    off_reg <= off_inc;
                    if (off_inc == 6'd0)
                    begin
                        ks_ready_reg <= 1'b0;
                        if (counter_reg == COUNTER_MAX)
                        begin
                            exh_reg <= 1'b1;
                        end
                        else
                        begin
                            counter_reg <= counter_reg + 32'd1;
                        end
                    end
                end
            end
            else if (state_reg == ST_FEED && ff_reg == 4'(STATE_WORDS - 1))
            begin
                ks_ready_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------ handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pending_reg <= 1'b1;
            end
            else if (produce)
            begin
                pending_reg <= 1'b0;
            end

            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (produce)
        begin
            out_data_reg.data_out <= eff_exh ? 8'h00 : (item_reg.data_in ^ ks_byte);
            out_data_reg.status   <= eff_exh;
        end
    end

endmodule

### src/ccs_checker.sv
// ----------------------------------------------------------------------------
// ccs_checker: port-level checks for the ChaCha20 stream cipher
// Tracks transfers in flight; checks in-flight bound, exhausted data, holds.
// ----------------------------------------------------------------------------
module ccs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input ccs_pkg::out_t out_data
);
    import ccs_pkg::*;

    logic       in_xfer, out_xfer;
    logic [1:0] inflight_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            unique case ({in_xfer, out_xfer})
                2'b10:   inflight_reg <= inflight_reg + 2'd1;
                2'b01:   inflight_reg <= inflight_reg - 2'd1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    // no result without a byte behind it
    a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("result shown with no byte in flight");

    // one held byte plus one output register at most
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("too many bytes in flight");

    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.data_out == 8'h00)
        else $error("exhausted result carries nonzero data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

endmodule

bind chacha20_stream_cipher ccs_checker u_ccs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
